// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== design/tpsu_pkg.sv =====
// Package of the touch panel scan unit: item kinds, offsets, state codes and helpers.
`default_nettype none

package tpsu_pkg;

    // Default converter width.
    localparam int ADC_BITS_DEF = 10;

    // Field widths fixed by the bus format.
    localparam int KIND_W = 3;
    localparam int OFFS_W = 5;
    localparam int HALF_W = 16;
    localparam int POS_W  = 10;
    localparam int IRQ_W  = 7;
    localparam int ERR_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CTRL_RD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CTRL_WR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BUF_RD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BUF_WR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEN     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESET   = 3'd6;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ADDR    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STROBE  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_CHANNEL = 2'd3;

    // Control block offsets.
    localparam logic [OFFS_W-1:0] OFF_CONTROL  = 5'h02;
    localparam logic [OFFS_W-1:0] OFF_INT_STAT = 5'h04;
    localparam logic [OFFS_W-1:0] OFF_INTERVAL = 5'h06;
    localparam logic [OFFS_W-1:0] OFF_STABLE   = 5'h08;
    localparam logic [OFFS_W-1:0] OFF_COMMAND  = 5'h0A;

    // Data buffer offsets.
    localparam logic [OFFS_W-1:0] OFF_CMD_RESULT = 5'h10;

    // Scan sequencer state codes.
    localparam logic [2:0] ST_DISABLE = 3'd0;
    localparam logic [2:0] ST_STANDBY = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_PENSCAN = 3'd4;
    localparam logic [2:0] ST_CMDSCAN = 3'd6;

    // Control register bits and masks.
    localparam logic [9:0]  CNT_STORED  = 10'h33E;
    localparam logic [15:0] CNT_STROBES = 16'h00C1;
    localparam int BIT_PWR     = 1;
    localparam int BIT_SEQ     = 2;
    localparam int BIT_ATSTART = 8;
    localparam int BIT_ATSTOP  = 9;

    // Interrupt status bits.
    localparam logic [15:0] INT_CAUSES = 16'h007D;
    localparam logic [15:0] INT_PENCHG = 16'h0001;
    localparam logic [15:0] INT_PAGE0  = 16'h0008;
    localparam logic [15:0] INT_PAGE1  = 16'h0010;
    localparam logic [15:0] INT_CMD    = 16'h0040;
    localparam int INT_OVP_BIT   = 15;
    localparam int INT_PAGE0_BIT = 3;
    localparam int INT_PAGE1_BIT = 4;

    // Command channels and the fixed reference value.
    localparam logic [3:0] CH_X    = 4'd4;
    localparam logic [3:0] CH_Y    = 4'd5;
    localparam logic [3:0] CH_ZREF = 4'd6;
    localparam logic [POS_W-1:0] CMD_ZREF = 10'd379;

    // Sample page layout.
    localparam int PAGE_WORDS   = 10;
    localparam int SAMPLE_WORDS = 5;
    localparam logic [3:0] SLOT_NONE = 4'd10;

    // Reset values of the timing and command registers.
    localparam logic [10:0] INTERVAL_RST = 11'd7;
    localparam logic [5:0]  STABLE_RST   = 6'd7;
    localparam logic [12:0] COMMAND_RST  = 13'd15;

    // Maps a data buffer offset to its sample slot, or SLOT_NONE.
    function automatic logic [3:0] buffer_slot(input logic [OFFS_W-1:0] off);
        logic [3:0] slot;
        case (off)
            5'h00:   slot = 4'd0;
            5'h02:   slot = 4'd1;
            5'h04:   slot = 4'd2;
            5'h06:   slot = 4'd3;
            5'h1C:   slot = 4'd4;
            5'h08:   slot = 4'd5;
            5'h0A:   slot = 4'd6;
            5'h0C:   slot = 4'd7;
            5'h0E:   slot = 4'd8;
            5'h1E:   slot = 4'd9;
            default: slot = SLOT_NONE;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== design/touch_panel_scan_unit_top.sv =====
// Touch panel scan unit: register block, scan sequencer and sample pages.
// The result of an item is registered and shown in the cycle after its input transfer.
// Throughput: one item per cycle; a new item is taken whenever the output
// register is empty or its result is taken in the same cycle.
// Reset: synchronous, active low; all unit state returns to its reset values
// and the output register is emptied.
`default_nettype none

module touch_panel_scan_unit_top #(
    parameter int ADC_BITS = tpsu_pkg::ADC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Fields from bit 0: offset[4:0], write_data[20:5], pen_down[21],
    // pen_x[31:22], pen_y[41:32], zero fill[47:42].
    input  wire logic [tpsu_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: kind[2:0].
    input  wire logic [tpsu_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // Fields from bit 0: read_data[15:0], irq_causes[22:16],
    // error_code[24:23], zero fill[31:25].
    output logic [tpsu_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    import tpsu_pkg::*;

    localparam logic [POS_W-1:0]    POS_MASK = POS_W'((1 << ADC_BITS) - 1);
    localparam logic [ADC_BITS-1:0] ADC_MAX  = '1;

    // Unpacked input fields.
    logic [KIND_W-1:0] in_kind;
    logic [OFFS_W-1:0] in_off;
    logic [HALF_W-1:0] in_wd;
    logic              in_down;
    logic [POS_W-1:0]  in_x;
    logic [POS_W-1:0]  in_y;
    logic              in_xfer;

    assign in_kind = i_s_axis_tuser;
    assign in_off  = i_s_axis_tdata[4:0];
    assign in_wd   = i_s_axis_tdata[20:5];
    assign in_down = i_s_axis_tdata[21];
    assign in_x    = i_s_axis_tdata[31:22];
    assign in_y    = i_s_axis_tdata[41:32];

    // Unit state.
    logic [2:0]          r_state,      n_state;
    logic [9:0]          r_ctrl,       n_ctrl;
    logic [15:0]         r_int,        n_int;
    logic [10:0]         r_interval,   n_interval;
    logic [5:0]          r_stable,     n_stable;
    logic [12:0]         r_command,    n_command;
    logic                r_pen_now,    n_pen_now;
    logic                r_pen_before, n_pen_before;
    logic [POS_W-1:0]    r_pos_x,      n_pos_x;
    logic [POS_W-1:0]    r_pos_y,      n_pos_y;
    logic [PAGE_WORDS-1:0] r_page_valid, n_page_valid;
    logic [ADC_BITS-1:0] r_page_data [PAGE_WORDS];
    logic [ADC_BITS-1:0] n_page_data [PAGE_WORDS];
    logic                r_next_page,  n_next_page;
    logic                r_cmd_valid,  n_cmd_valid;
    logic [ADC_BITS-1:0] r_cmd_data,   n_cmd_data;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Next state and result of the item at the input.
    always_comb begin
        logic [HALF_W-1:0]   rd;
        logic [ERR_W-1:0]    err;
        logic                do_sample;
        logic                do_cmd;
        logic [9:0]          new_ctrl;
        logic [3:0]          slot;
        logic [15:0]         clr;
        logic [ADC_BITS-1:0] cmd_v;
        logic                cmd_ok;
        logic [3:0]          idx;

        n_state      = r_state;
        n_ctrl       = r_ctrl;
        n_int        = r_int;
        n_interval   = r_interval;
        n_stable     = r_stable;
        n_command    = r_command;
        n_pen_now    = r_pen_now;
        n_pen_before = r_pen_before;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_page_valid = r_page_valid;
        n_page_data  = r_page_data;
        n_next_page  = r_next_page;
        n_cmd_valid  = r_cmd_valid;
        n_cmd_data   = r_cmd_data;
        rd           = '0;
        err          = ERR_NONE;
        do_sample    = 1'b0;
        do_cmd       = 1'b0;
        new_ctrl     = in_wd[9:0] & CNT_STORED;
        slot         = buffer_slot(in_off);
        clr          = in_wd & INT_CAUSES;
        cmd_v        = '0;
        cmd_ok       = 1'b0;
        idx          = '0;

        case (in_kind)
            KIND_CTRL_RD: begin
                case (in_off)
                    OFF_CONTROL:  rd = {1'b0, r_pen_before, r_pen_now, r_state, r_ctrl};
                    OFF_INT_STAT: rd = r_int;
                    OFF_INTERVAL: rd = HALF_W'(r_interval);
                    OFF_STABLE:   rd = HALF_W'(r_stable);
                    OFF_COMMAND:  rd = HALF_W'(r_command);
                    default:      err = ERR_ADDR;
                endcase
            end
            KIND_CTRL_WR: begin
                case (in_off)
                    OFF_CONTROL: begin
                        if ((in_wd & CNT_STROBES) != '0) begin
                            err = ERR_STROBE;
                        end else begin
                            n_ctrl = new_ctrl;
                            // Power bit edges.
                            if (!r_ctrl[BIT_PWR] && new_ctrl[BIT_PWR] &&
                                n_state == ST_DISABLE) begin
                                n_state = ST_STANDBY;
                            end else if (r_ctrl[BIT_PWR] && !new_ctrl[BIT_PWR]) begin
                                n_state = ST_DISABLE;
                            end
                            // Sequencer enable edges.
                            if (!r_ctrl[BIT_SEQ] && new_ctrl[BIT_SEQ] &&
                                n_state == ST_STANDBY) begin
                                n_state = (new_ctrl[4:3] == 2'd1) ? ST_CMDSCAN : ST_WAIT;
                            end else if (r_ctrl[BIT_SEQ] && !new_ctrl[BIT_SEQ] &&
                                         n_state != ST_DISABLE) begin
                                n_state = ST_STANDBY;
                            end
                            // A mode change restarts a running sequencer.
                            if (r_ctrl[4:3] != new_ctrl[4:3] && new_ctrl[BIT_SEQ] &&
                                n_state != ST_DISABLE && n_state != ST_STANDBY) begin
                                n_state = (new_ctrl[4:3] == 2'd1) ? ST_CMDSCAN : ST_WAIT;
                            end
                            // A pen already down starts a scan at once.
                            if (r_pen_now && new_ctrl[BIT_SEQ] && new_ctrl[BIT_ATSTART] &&
                                n_state == ST_WAIT) begin
                                n_state   = ST_PENSCAN;
                                do_sample = 1'b1;
                            end else if (r_pen_now && n_state == ST_CMDSCAN) begin
                                do_cmd = 1'b1;
                            end
                        end
                    end
                    OFF_INT_STAT: begin
                        // Write one to clear; a cleared page cause drops its valid bits.
                        n_int = r_int & ~clr;
                        if (clr[INT_PAGE0_BIT]) begin
                            n_page_valid[SAMPLE_WORDS-1:0] = '0;
                        end
                        if (clr[INT_PAGE1_BIT]) begin
                            n_page_valid[PAGE_WORDS-1:SAMPLE_WORDS] = '0;
                        end
                    end
                    OFF_INTERVAL: n_interval = in_wd[10:0];
                    OFF_STABLE:   n_stable   = in_wd[5:0];
                    OFF_COMMAND:  n_command  = in_wd[12:0];
                    default:      err = ERR_ADDR;
                endcase
            end
            KIND_BUF_RD: begin
                if (in_off == OFF_CMD_RESULT) begin
                    rd     = HALF_W'(r_cmd_data);
                    rd[15] = r_cmd_valid;
                end else if (slot != SLOT_NONE) begin
                    rd     = HALF_W'(r_page_data[slot]);
                    rd[15] = r_page_valid[slot];
                end else begin
                    err = ERR_ADDR;
                end
            end
            KIND_BUF_WR: begin
                err = ERR_ADDR;
            end
            KIND_PEN: begin
                n_pos_x = in_x & POS_MASK;
                n_pos_y = in_y & POS_MASK;
                if (in_down != r_pen_now) begin
                    n_pen_before = r_pen_now;
                    n_pen_now    = in_down;
                    n_int        = n_int | INT_PENCHG;
                    if (in_down) begin
                        if (r_ctrl[BIT_SEQ] && r_ctrl[BIT_ATSTART] && n_state == ST_WAIT) begin
                            n_state = ST_PENSCAN;
                        end
                        if (n_state == ST_PENSCAN) begin
                            do_sample = 1'b1;
                        end
                    end else if (n_state == ST_PENSCAN && r_ctrl[BIT_ATSTOP]) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            KIND_TICK: begin
                if (r_pen_now && r_state == ST_PENSCAN) begin
                    do_sample = 1'b1;
                end else if (r_pen_now && r_state == ST_CMDSCAN) begin
                    do_cmd = 1'b1;
                end
            end
            KIND_RESET: begin
                n_state      = ST_DISABLE;
                n_ctrl       = '0;
                n_int        = '0;
                n_interval   = INTERVAL_RST;
                n_stable     = STABLE_RST;
                n_command    = COMMAND_RST;
                n_pen_now    = 1'b0;
                n_pen_before = 1'b0;
                n_pos_x      = '0;
                n_pos_y      = '0;
                n_page_valid = '0;
                for (int i = 0; i < PAGE_WORDS; i++) begin
                    n_page_data[i] = '0;
                end
                n_next_page  = 1'b0;
                n_cmd_valid  = 1'b0;
                n_cmd_data   = '0;
            end
            default: begin
            end
        endcase

        // Fill the next page with the five sample words.
        if (do_sample) begin
            for (int k = 0; k < SAMPLE_WORDS; k++) begin
                idx = 4'(k) + (r_next_page ? 4'(SAMPLE_WORDS) : 4'd0);
                n_page_valid[idx] = 1'b1;
                case (k)
                    0:       n_page_data[idx] = ADC_BITS'(n_pos_x);
                    1:       n_page_data[idx] = ~ADC_BITS'(n_pos_x);
                    2:       n_page_data[idx] = ADC_BITS'(n_pos_y);
                    3:       n_page_data[idx] = ~ADC_BITS'(n_pos_y);
                    default: n_page_data[idx] = ADC_MAX;
                endcase
            end
            n_int              = n_int | (r_next_page ? INT_PAGE1 : INT_PAGE0);
            n_int[INT_OVP_BIT] = r_next_page;
            n_next_page        = !r_next_page;
        end

        // Command scan of the selected channel.
        if (do_cmd) begin
            case (r_command[3:0])
                CH_X:    begin cmd_v = ADC_BITS'(n_pos_x);  cmd_ok = 1'b1; end
                CH_Y:    begin cmd_v = ADC_BITS'(n_pos_y);  cmd_ok = 1'b1; end
                CH_ZREF: begin cmd_v = ADC_BITS'(CMD_ZREF); cmd_ok = 1'b1; end
                default: begin cmd_v = '0;                  cmd_ok = 1'b0; end
            endcase
            if (cmd_ok) begin
                n_cmd_valid = 1'b1;
                n_cmd_data  = cmd_v;
                n_int       = n_int | INT_CMD;
            end else begin
                err = ERR_CHANNEL;
            end
        end

        n_out_data = {7'd0, err, IRQ_W'(n_int & INT_CAUSES), rd};
    end

    // State registers, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_DISABLE;
            r_ctrl       <= '0;
            r_int        <= '0;
            r_interval   <= INTERVAL_RST;
            r_stable     <= STABLE_RST;
            r_command    <= COMMAND_RST;
            r_pen_now    <= 1'b0;
            r_pen_before <= 1'b0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_page_valid <= '0;
            for (int i = 0; i < PAGE_WORDS; i++) begin
                r_page_data[i] <= '0;
            end
            r_next_page  <= 1'b0;
            r_cmd_valid  <= 1'b0;
            r_cmd_data   <= '0;
        end else if (in_xfer) begin
            r_state      <= n_state;
            r_ctrl       <= n_ctrl;
            r_int        <= n_int;
            r_interval   <= n_interval;
            r_stable     <= n_stable;
            r_command    <= n_command;
            r_pen_now    <= n_pen_now;
            r_pen_before <= n_pen_before;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_page_valid <= n_page_valid;
            r_page_data  <= n_page_data;
            r_next_page  <= n_next_page;
            r_cmd_valid  <= n_cmd_valid;
            r_cmd_data   <= n_cmd_data;
        end
    end

    // Output register: filled on an input transfer, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/tpsu_checker.sv =====
// Port checker of the touch panel scan unit and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module tpsu_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic [tpsu_pkg::KIND_W-1:0]     i_s_axis_tuser,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [tpsu_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    import tpsu_pkg::*;

    logic in_xfer;

    assign in_xfer = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Items other than reads return zero read data in the next cycle.
    `ASSERT_NEXT(a_rd_zero, i_clk, i_rst_n, in_xfer && i_s_axis_tuser != KIND_CTRL_RD && i_s_axis_tuser != KIND_BUF_RD, o_m_axis_tvalid && o_m_axis_tdata[15:0] == 16'd0)

    // A soft reset item returns an all-zero result.
    `ASSERT_NEXT(a_reset_zero, i_clk, i_rst_n, in_xfer && i_s_axis_tuser == KIND_RESET, o_m_axis_tvalid && o_m_axis_tdata == '0)

    // A data buffer write is always refused.
    `ASSERT_NEXT(a_bufwr_err, i_clk, i_rst_n, in_xfer && i_s_axis_tuser == KIND_BUF_WR, o_m_axis_tvalid && o_m_axis_tdata[24:23] == ERR_ADDR)

    // Masked-out cause bit and fill bits stay low.
    `ASSERT_SAME(a_irq_mask, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[17] == 1'b0 && o_m_axis_tdata[31:25] == 7'd0)

endmodule

bind touch_panel_scan_unit_top tpsu_checker u_tpsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/tpsu_scan_checker.sv =====
`timescale 1ns / 100ps
// Checker for the touch panel scan unit: predicts each response and compares it field by field.
module tpsu_scan_checker #(
    parameter int ADC_BITS = tpsu_pkg::ADC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    input  wire logic                                i_s_axis_tready,
    // Fields from bit 0: offset[4:0], write_data[20:5], pen_down[21],
    // pen_x[31:22], pen_y[41:32], zero fill[47:42].
    input  wire logic [tpsu_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // Fields from bit 0: kind[2:0].
    input  wire logic [tpsu_pkg::KIND_W-1:0]        i_s_axis_tuser,
    input  wire logic                                i_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // Fields from bit 0: read_data[15:0], irq_causes[22:16],
    // error_code[24:23], zero fill[31:25].
    input  wire logic [tpsu_pkg::OUT_DATA_W-1:0]    i_m_axis_tdata,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    import tpsu_pkg::*;

    // The two mode bits of the control register; mode 1 is command scan.
    localparam int         MODE_LSB     = 3;
    localparam logic [1:0] MODE_COMMAND = 2'd1;

    localparam logic [15:0] SAMPLE_VALID = 16'h8000;
    localparam logic [15:0] ADC_FULL     = (16'd1 << ADC_BITS) - 16'd1;

    typedef struct packed {
        logic [HALF_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq;
        logic [ERR_W-1:0]  err_code;
    } scan_response_t;

    // Mirror of the unit's state.
    logic [2:0]        sequencer_state;
    logic [9:0]        control_reg;
    logic [15:0]       irq_status;
    logic [10:0]       interval_reg;
    logic [5:0]        settle_reg;
    logic [12:0]       command_reg;
    logic              pen_is_down;
    logic              pen_was_down;
    logic [15:0]       pen_pos_x;
    logic [15:0]       pen_pos_y;
    logic [15:0]       sample_page [PAGE_WORDS];
    logic              fill_page;
    logic [15:0]       conversion_word;

    scan_response_t    expected_responses [$];
    int                mismatches = 0;

    function automatic void reset_unit_model();
        sequencer_state = ST_DISABLE;
        control_reg     = '0;
        irq_status      = '0;
        interval_reg    = INTERVAL_RST;
        settle_reg      = STABLE_RST;
        command_reg     = COMMAND_RST;
        pen_is_down     = 1'b0;
        pen_was_down    = 1'b0;
        pen_pos_x       = '0;
        pen_pos_y       = '0;
        for (int i = 0; i < PAGE_WORDS; i++) sample_page[i] = '0;
        fill_page       = 1'b0;
        conversion_word = '0;
    endfunction

    // Fills the current page with four pen readings and a full-scale word, then flips pages.
    function automatic void store_sample();
        int base;
        base = fill_page ? SAMPLE_WORDS : 0;
        sample_page[base]     = SAMPLE_VALID | (pen_pos_x & ADC_FULL);
        sample_page[base + 1] = SAMPLE_VALID | ((ADC_FULL - pen_pos_x) & ADC_FULL);
        sample_page[base + 2] = SAMPLE_VALID | (pen_pos_y & ADC_FULL);
        sample_page[base + 3] = SAMPLE_VALID | ((ADC_FULL - pen_pos_y) & ADC_FULL);
        sample_page[base + 4] = SAMPLE_VALID | ADC_FULL;
        irq_status |= fill_page ? INT_PAGE1 : INT_PAGE0;
        irq_status[INT_OVP_BIT] = fill_page;
        fill_page = ~fill_page;
    endfunction

    // One conversion of the channel named in the command register.
    function automatic logic [ERR_W-1:0] convert_channel();
        logic [15:0] level;
        case (command_reg[3:0])
            CH_X:    level = pen_pos_x;
            CH_Y:    level = pen_pos_y;
            CH_ZREF: level = {6'd0, CMD_ZREF};
            default: return ERR_CHANNEL;
        endcase
        conversion_word = SAMPLE_VALID | (level & ADC_FULL);
        irq_status |= INT_CMD;
        return ERR_NONE;
    endfunction

    // Control register write and the sequencer moves it triggers.
    function automatic logic [ERR_W-1:0] apply_control(input logic [15:0] value);
        logic [9:0] prev;
        logic [1:0] prev_mode;
        logic [1:0] new_mode;
        logic [2:0] run_state;
        if ((value & CNT_STROBES) != 16'd0) return ERR_STROBE;
        prev        = control_reg;
        control_reg = value[9:0] & CNT_STORED;
        prev_mode   = prev[MODE_LSB +: 2];
        new_mode    = control_reg[MODE_LSB +: 2];
        run_state   = (new_mode == MODE_COMMAND) ? ST_CMDSCAN : ST_WAIT;

        if (!prev[BIT_PWR] && control_reg[BIT_PWR] && sequencer_state == ST_DISABLE) begin
            sequencer_state = ST_STANDBY;
        end else if (prev[BIT_PWR] && !control_reg[BIT_PWR]) begin
            sequencer_state = ST_DISABLE;
        end

        if (!prev[BIT_SEQ] && control_reg[BIT_SEQ] && sequencer_state == ST_STANDBY) begin
            sequencer_state = run_state;
        end else if (prev[BIT_SEQ] && !control_reg[BIT_SEQ] &&
                     sequencer_state != ST_DISABLE) begin
            sequencer_state = ST_STANDBY;
        end

        // A mode change restarts a running sequencer in the new mode.
        if (prev_mode != new_mode && control_reg[BIT_SEQ] &&
            sequencer_state != ST_DISABLE && sequencer_state != ST_STANDBY) begin
            sequencer_state = run_state;
        end

        if (pen_is_down && control_reg[BIT_SEQ] && control_reg[BIT_ATSTART] &&
            sequencer_state == ST_WAIT) begin
            sequencer_state = ST_PENSCAN;
            store_sample();
        end else if (pen_is_down && sequencer_state == ST_CMDSCAN) begin
            return convert_channel();
        end
        return ERR_NONE;
    endfunction

    // Applies one accepted item to the mirror and returns the response it must produce.
    function automatic scan_response_t predict_response(input logic [KIND_W-1:0] kind,
                                                        input logic [IN_DATA_W-1:0] data);
        logic [OFFS_W-1:0] off;
        logic [15:0]       wd;
        logic              down;
        logic [15:0]       clr;
        int                slot;
        scan_response_t    resp;
        off  = data[4:0];
        wd   = data[20:5];
        down = data[21];
        resp = '0;
        case (kind)
            KIND_CTRL_RD: begin
                case (off)
                    OFF_CONTROL:  resp.read_data = {1'b0, pen_was_down, pen_is_down,
                                                    sequencer_state, control_reg & CNT_STORED};
                    OFF_INT_STAT: resp.read_data = irq_status;
                    OFF_INTERVAL: resp.read_data = {5'd0, interval_reg};
                    OFF_STABLE:   resp.read_data = {10'd0, settle_reg};
                    OFF_COMMAND:  resp.read_data = {3'd0, command_reg};
                    default:      resp.err_code = ERR_ADDR;
                endcase
            end
            KIND_CTRL_WR: begin
                case (off)
                    OFF_CONTROL: resp.err_code = apply_control(wd);
                    OFF_INT_STAT: begin
                        // Clearing a page cause also drops the valid flags of that page.
                        clr = wd & INT_CAUSES;
                        irq_status &= ~clr;
                        if (clr[INT_PAGE0_BIT])
                            for (int i = 0; i < SAMPLE_WORDS; i++)
                                sample_page[i] &= ~SAMPLE_VALID;
                        if (clr[INT_PAGE1_BIT])
                            for (int i = SAMPLE_WORDS; i < PAGE_WORDS; i++)
                                sample_page[i] &= ~SAMPLE_VALID;
                    end
                    OFF_INTERVAL: interval_reg = wd[10:0];
                    OFF_STABLE:   settle_reg = wd[5:0];
                    OFF_COMMAND:  command_reg = wd[12:0];
                    default:      resp.err_code = ERR_ADDR;
                endcase
            end
            KIND_BUF_RD: begin
                // Even offsets below 0x10 hold X+, X-, Y+, Y- of both pages; the Z words
                // sit at the top of the block.
                slot = -1;
                if (!off[4] && !off[0])
                    slot = (off[3] ? SAMPLE_WORDS : 0) + off[2:1];
                else if (off[4:2] == 3'b111 && !off[0])
                    slot = (off[1] ? SAMPLE_WORDS : 0) + SAMPLE_WORDS - 1;
                if (off == OFF_CMD_RESULT)
                    resp.read_data = conversion_word;
                else if (slot >= 0)
                    resp.read_data = sample_page[slot];
                else
                    resp.err_code = ERR_ADDR;
            end
            KIND_BUF_WR: resp.err_code = ERR_ADDR;
            KIND_PEN: begin
                pen_pos_x = {6'd0, data[31:22]} & ADC_FULL;
                pen_pos_y = {6'd0, data[41:32]} & ADC_FULL;
                if (down != pen_is_down) begin
                    pen_was_down = pen_is_down;
                    pen_is_down  = down;
                    irq_status  |= INT_PENCHG;
                    if (down) begin
                        if (control_reg[BIT_SEQ] && control_reg[BIT_ATSTART] &&
                            sequencer_state == ST_WAIT)
                            sequencer_state = ST_PENSCAN;
                        if (sequencer_state == ST_PENSCAN) store_sample();
                    end else if (sequencer_state == ST_PENSCAN && control_reg[BIT_ATSTOP]) begin
                        sequencer_state = ST_WAIT;
                    end
                end
            end
            KIND_TICK: begin
                if (pen_is_down && sequencer_state == ST_PENSCAN)
                    store_sample();
                else if (pen_is_down && sequencer_state == ST_CMDSCAN)
                    resp.err_code = convert_channel();
            end
            KIND_RESET: reset_unit_model();
            default: ;
        endcase
        resp.irq = irq_status[IRQ_W-1:0] & INT_CAUSES[IRQ_W-1:0];
        return resp;
    endfunction

    // Predict on every input transfer, compare on every output transfer.
    always @(posedge i_clk) begin
        scan_response_t want;
        scan_response_t got;
        if (!i_rst_n) begin
            reset_unit_model();
            expected_responses.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_responses.push_back(predict_response(i_s_axis_tuser, i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.read_data = i_m_axis_tdata[15:0];
                got.irq       = i_m_axis_tdata[22:16];
                got.err_code  = i_m_axis_tdata[24:23];
                if (expected_responses.size() == 0) begin
                    $display("%0t: response with none expected: read_data %h irq %h error %0d",
                             $time, got.read_data, got.irq, got.err_code);
                    mismatches++;
                end else begin
                    want = expected_responses.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                        mismatches++;
                    end
                    if (got.irq !== want.irq) begin
                        $display("%0t: irq_causes expected %h actual %h",
                                 $time, want.irq, got.irq);
                        mismatches++;
                    end
                    if (got.err_code !== want.err_code) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.err_code, got.err_code);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_responses.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_touch_panel_scan_unit_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the touch panel scan unit: clock, reset, stimulus, back pressure and verdict.
module tb_touch_panel_scan_unit_top;
    import tpsu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd7;
    localparam logic [OFFS_W-1:0] OFF_BAD      = 5'h1F;
    localparam logic [OFFS_W-1:0] OFF_PAGE0_XP = 5'h00;
    localparam logic [OFFS_W-1:0] OFF_PAGE1_Z  = 5'h1E;

    // Mode field of the control register and the value that selects command scan.
    localparam logic [15:0] CTRL_MODE_MASK    = 16'h0018;
    localparam logic [15:0] CTRL_MODE_COMMAND = 16'h0008;

    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;
    int                    items_sent = 0;
    int                    cycle_count = 0;
    bit                    sender_steady = 1'b0;

    touch_panel_scan_unit_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tpsu_scan_checker u_scan_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one item after a random gap and returns at the edge of its transfer.
    // Valid stays high when the next item follows without a gap.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [OFFS_W-1:0] off,
                             input logic [15:0] wd, input logic down,
                             input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        int gap;
        if (items_sent % 32 == 0) sender_steady = ($urandom_range(0, 3) == 0);
        gap = sender_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, py, px, down, wd, off};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [POS_W-1:0] pen_coord();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Register or buffer access; the pen fields carry noise.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [OFFS_W-1:0] off,
                           input logic [15:0] wd);
        send_item(kind, off, wd, $urandom_range(0, 1), pen_coord(), pen_coord());
    endtask

    task automatic send_pen(input logic down, input logic [POS_W-1:0] px,
                            input logic [POS_W-1:0] py);
        send_item(KIND_PEN, $urandom_range(0, 31), $urandom_range(0, 16'hFFFF), down, px, py);
    endtask

    function automatic logic [OFFS_W-1:0] pick_ctrl_offset();
        case ($urandom_range(0, 4))
            0:       return OFF_CONTROL;
            1:       return OFF_INT_STAT;
            2:       return OFF_INTERVAL;
            3:       return OFF_STABLE;
            default: return OFF_COMMAND;
        endcase
    endfunction

    function automatic logic [OFFS_W-1:0] pick_buffer_offset();
        case ($urandom_range(0, 11))
            0:       return OFF_CMD_RESULT;
            1:       return OFF_PAGE1_Z;
            2:       return OFF_PAGE1_Z - 5'd2;
            default: return $urandom_range(0, 7) * 2;
        endcase
    endfunction

    // A power-up with random settings, a run of pen activity and accesses, and an optional exit.
    task automatic scan_session();
        logic [15:0] ctrl;
        logic [15:0] wd;
        logic [15:0] strobe;
        int          steps;
        if ($urandom_range(0, 3) != 0) begin
            wd = $urandom_range(0, 16'hFFFF);
            wd[3:0] = CH_X + $urandom_range(0, 2);
            send_op(KIND_CTRL_WR, OFF_COMMAND, wd);
        end
        ctrl = $urandom_range(0, 16'hFFFF) & {6'd0, CNT_STORED};
        ctrl[BIT_PWR] = 1'b1;
        ctrl[BIT_SEQ] = ($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 3) != 0) ctrl[BIT_ATSTART] = 1'b1;
        if ($urandom_range(0, 2) == 0) ctrl = (ctrl & ~CTRL_MODE_MASK) | CTRL_MODE_COMMAND;
        // Sometimes pass through standby before enabling the sequencer.
        if ($urandom_range(0, 2) == 0) begin
            wd = ctrl;
            wd[BIT_SEQ] = 1'b0;
            send_op(KIND_CTRL_WR, OFF_CONTROL, wd);
        end
        send_op(KIND_CTRL_WR, OFF_CONTROL, ctrl);

        steps = $urandom_range(6, 24);
        repeat (steps) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_pen($urandom_range(0, 1), pen_coord(), pen_coord());
                3, 4:    send_op(KIND_TICK, $urandom_range(0, 31), $urandom_range(0, 16'hFFFF));
                5:       send_op(KIND_BUF_RD, pick_buffer_offset(), $urandom_range(0, 16'hFFFF));
                6:       send_op(KIND_CTRL_RD, pick_ctrl_offset(), $urandom_range(0, 16'hFFFF));
                7:       send_op(KIND_CTRL_WR, OFF_INT_STAT, $urandom_range(0, 16'hFFFF));
                8: begin
                    wd = ctrl;
                    case ($urandom_range(0, 4))
                        0: ctrl = (ctrl & ~CTRL_MODE_MASK) |
                                  ($urandom_range(0, 16'hFFFF) & CTRL_MODE_MASK);
                        1: ctrl[BIT_ATSTOP]  = ~ctrl[BIT_ATSTOP];
                        2: ctrl[BIT_ATSTART] = ~ctrl[BIT_ATSTART];
                        3: ctrl[BIT_SEQ]     = ~ctrl[BIT_SEQ];
                        default: begin
                            // A strobe bit makes the whole write void.
                            strobe = CNT_STROBES & $urandom_range(0, 16'hFFFF);
                            if (strobe == 16'd0) strobe = CNT_STROBES;
                            wd = ctrl | strobe;
                        end
                    endcase
                    if (wd == ctrl || (wd & CNT_STROBES) == 16'd0) wd = ctrl;
                    send_op(KIND_CTRL_WR, OFF_CONTROL, wd);
                end
                default: begin
                    wd = $urandom_range(0, 16'hFFFF);
                    if ($urandom_range(0, 3) != 0) wd[3:0] = CH_X + $urandom_range(0, 2);
                    send_op(KIND_CTRL_WR, pick_ctrl_offset() == OFF_CONTROL ? OFF_COMMAND :
                            pick_ctrl_offset(), wd);
                end
            endcase
        end

        case ($urandom_range(0, 3))
            0: begin
                ctrl[BIT_PWR] = 1'b0;
                send_op(KIND_CTRL_WR, OFF_CONTROL, ctrl);
            end
            1:       send_op(KIND_RESET, $urandom_range(0, 31), $urandom_range(0, 16'hFFFF));
            default: ;
        endcase
    endtask

    // Result side: random stalls, stretches without stalls, and two long holds.
    initial begin
        int stall;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 32 == 0) steady = ($urandom_range(0, 3) == 0);
            if (taken == 150 || taken == 450)
                stall = HOLD_CYCLES;
            else
                stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        int first_random;
        int burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: reset values, error paths, both scan modes and the special items.
        send_op(KIND_CTRL_RD, OFF_CONTROL, 16'h0000);
        send_op(KIND_CTRL_RD, OFF_COMMAND, 16'hFFFF);
        send_op(KIND_CTRL_RD, OFF_BAD, 16'h0000);
        send_op(KIND_BUF_WR, OFF_CMD_RESULT, 16'hFFFF);
        send_op(KIND_CTRL_WR, OFF_CONTROL, 16'hFFFF);
        send_op(KIND_CTRL_WR, OFF_BAD, 16'hFFFF);
        send_op(KIND_CTRL_WR, OFF_INTERVAL, 16'hFFFF);
        send_op(KIND_CTRL_WR, OFF_STABLE, 16'hFFFF);
        send_op(KIND_CTRL_WR, OFF_COMMAND, {12'hFFF, CH_X});
        send_pen(1'b1, 10'd1023, 10'd0);
        // Enabling auto start with the pen already down takes a sample at once.
        send_op(KIND_CTRL_WR, OFF_CONTROL, 16'h0000 | (16'd1 << BIT_PWR) | (16'd1 << BIT_SEQ) |
                (16'd1 << BIT_ATSTART) | (16'd1 << BIT_ATSTOP));
        send_op(KIND_TICK, OFF_PAGE0_XP, 16'h0000);
        send_op(KIND_BUF_RD, OFF_PAGE0_XP, 16'h0000);
        send_op(KIND_BUF_RD, OFF_PAGE1_Z, 16'h0000);
        send_op(KIND_CTRL_RD, OFF_INT_STAT, 16'h0000);
        send_op(KIND_CTRL_WR, OFF_INT_STAT, 16'hFFFF);
        send_pen(1'b0, 10'd0, 10'd1023);
        send_op(KIND_CTRL_WR, OFF_CONTROL, (16'd1 << BIT_PWR) | (16'd1 << BIT_SEQ) |
                (16'd1 << BIT_ATSTART) | CTRL_MODE_COMMAND);
        send_pen(1'b1, 10'd512, 10'd1023);
        send_op(KIND_TICK, OFF_PAGE0_XP, 16'h0000);
        send_op(KIND_BUF_RD, OFF_CMD_RESULT, 16'h0000);
        // A channel outside X, Y and Z reference makes the scan fail.
        send_op(KIND_CTRL_WR, OFF_COMMAND, 16'h0000);
        send_op(KIND_TICK, OFF_PAGE0_XP, 16'h0000);
        send_op(KIND_CTRL_WR, OFF_CONTROL, 16'h0000);
        send_op(KIND_RESET, OFF_BAD, 16'hFFFF);
        send_op(KIND_NONE, OFF_BAD, 16'hFFFF);

        // Random part: mostly well-formed scan sessions, some raw noise.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                    send_item($urandom_range(0, 7), $urandom_range(0, 31),
                              $urandom_range(0, 16'hFFFF), $urandom_range(0, 1),
                              $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                scan_session();
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
